/* rtl/core/cdsk_pkg.sv */
// Package for the codebook delay-skew block: lane count, derived widths,
// register index codes and the per-lane control bundle.
// No dependencies.
package cdsk_pkg;

    localparam int LANES         = 8;
    localparam int CODE_BITS_DEF = 16;
    localparam int LANE_W        = $clog2(LANES + 1);
    localparam int HIST_DEPTH    = (LANES > 1) ? LANES - 1 : 1;
    localparam int HIDX_W        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FRAMES_W      = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int LANES_REG_W   = 4;

    localparam logic [FRAMES_W-1:0]    FRAMES_MAX   = '1;
    localparam logic [LANES_REG_W-1:0] LANES_RESET  = LANES_REG_W'(8);
    localparam logic [CFG_DATA_W-1:0]  BEGIN_RESET  = CFG_DATA_W'(1024);
    localparam logic [CFG_DATA_W-1:0]  END_RESET    = CFG_DATA_W'(1025);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION = 2'd0,
        CFG_LANES     = 2'd1,
        CFG_BEGIN     = 2'd2,
        CFG_END       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                push;       // frame accepted, shift history
        logic                fl_load;    // copy history into flush line
        logic                fl_step;    // flush beat issued, shift flush line
        logic                flushing;
        logic                reverse;
        logic                zero_out;   // short-stream error beat
        logic [LANE_W-1:0]   lanes_act;
        logic [FRAMES_W-1:0] frames;
        logic [LANE_W-1:0]   flush_j;
        logic [FRAMES_W-1:0] flush_n;
    } lane_ctrl_t;

endpackage

/* rtl/core/codebook_delay_skew.sv */
// Top level of the codebook delay-skew block: configuration, stream control,
// flush sequencing and the result register. Depends on cdsk_pkg and cdsk_lane.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_code_0..7, s_final_frame
//   m_       out  m_valid/m_ready    m_out_0..7, m_end_of_stream, m_too_short
//   cfg_     in   cfg_we             cfg_idx, cfg_wdata
//
// One frame is taken per cycle while s_ready is high; each lane's shift chain and
// the single result register set this. After a final frame in apply mode the block
// issues codebooks_in_use-1 flush beats, one per cycle unless the output stalls,
// with s_ready low meanwhile. Reset is synchronous; history clears at once,
// no clearing pass. A stalled result beat holds s_ready low until m_ready takes it.
module codebook_delay_skew #(
    parameter int CODE_BITS = cdsk_pkg::CODE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [cdsk_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [cdsk_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [CODE_BITS-1:0]            s_code_0,
    input  logic [CODE_BITS-1:0]            s_code_1,
    input  logic [CODE_BITS-1:0]            s_code_2,
    input  logic [CODE_BITS-1:0]            s_code_3,
    input  logic [CODE_BITS-1:0]            s_code_4,
    input  logic [CODE_BITS-1:0]            s_code_5,
    input  logic [CODE_BITS-1:0]            s_code_6,
    input  logic [CODE_BITS-1:0]            s_code_7,
    input  logic                            s_final_frame,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [CODE_BITS-1:0]            m_out_0,
    output logic [CODE_BITS-1:0]            m_out_1,
    output logic [CODE_BITS-1:0]            m_out_2,
    output logic [CODE_BITS-1:0]            m_out_3,
    output logic [CODE_BITS-1:0]            m_out_4,
    output logic [CODE_BITS-1:0]            m_out_5,
    output logic [CODE_BITS-1:0]            m_out_6,
    output logic [CODE_BITS-1:0]            m_out_7,
    output logic                            m_end_of_stream,
    output logic                            m_too_short
);
    import cdsk_pkg::*;

    logic                   direction_reg;
    logic [LANES_REG_W-1:0] lanes_reg;
    logic [CFG_DATA_W-1:0]  begin_reg;
    logic [CFG_DATA_W-1:0]  end_reg;

    logic [FRAMES_W-1:0]    frames_reg, frames_next;
    logic                   flush_reg, flush_next;
    logic [LANE_W-1:0]      flush_j_reg, flush_j_next;
    logic [FRAMES_W-1:0]    flush_n_reg, flush_n_next;

    logic                   m_valid_reg, m_valid_next;
    logic [CODE_BITS-1:0]   m_code_reg [LANES];
    logic                   m_eos_reg, m_eos_next;
    logic                   m_short_reg, m_short_next;

    logic [CODE_BITS-1:0]   code_in  [LANES];
    logic [CODE_BITS-1:0]   lane_out [LANES];
    logic [CODE_BITS-1:0]   begin_code;
    logic [CODE_BITS-1:0]   end_code;
    logic [LANE_W-1:0]      c_act;
    logic [FRAMES_W-1:0]    n_sat;
    logic                   out_free;
    logic                   accept;
    logic                   flush_beat;
    logic                   flush_start;
    logic                   load;
    lane_ctrl_t             ctrl;

    assign code_in[0] = s_code_0;
    assign code_in[1] = s_code_1;
    assign code_in[2] = s_code_2;
    assign code_in[3] = s_code_3;
    assign code_in[4] = s_code_4;
    assign code_in[5] = s_code_5;
    assign code_in[6] = s_code_6;
    assign code_in[7] = s_code_7;

    assign begin_code = CODE_BITS'(begin_reg);
    assign end_code   = CODE_BITS'(end_reg);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= 1'b0;
            lanes_reg     <= LANES_RESET;
            begin_reg     <= BEGIN_RESET;
            end_reg       <= END_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_idx))
                CFG_DIRECTION: direction_reg <= cfg_wdata[0];
                CFG_LANES:     lanes_reg     <= cfg_wdata[LANES_REG_W-1:0];
                CFG_BEGIN:     begin_reg     <= cfg_wdata;
                CFG_END:       end_reg       <= cfg_wdata;
            endcase
        end
    end

    // zero lanes acts as one, anything above the lane count as the lane count
    always_comb begin
        if (lanes_reg == '0) begin
            c_act = LANE_W'(1);
        end else if (int'(lanes_reg) > LANES) begin
            c_act = LANE_W'(LANES);
        end else begin
            c_act = LANE_W'(lanes_reg);
        end
    end

    assign n_sat       = (frames_reg == FRAMES_MAX) ? FRAMES_MAX : frames_reg + FRAMES_W'(1);
    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = !flush_reg && out_free;
    assign accept      = s_valid && s_ready;
    assign flush_beat  = flush_reg && out_free;
    assign flush_start = accept && !direction_reg && s_final_frame && (c_act > LANE_W'(1));

    // result beat selection
    always_comb begin
        load         = 1'b0;
        m_eos_next   = m_eos_reg;
        m_short_next = m_short_reg;
        if (flush_beat) begin
            load         = 1'b1;
            m_eos_next   = (flush_j_reg == c_act - LANE_W'(1));
            m_short_next = 1'b0;
        end else if (accept) begin
            if (!direction_reg) begin
                load         = 1'b1;
                m_eos_next   = s_final_frame && (c_act == LANE_W'(1));
                m_short_next = 1'b0;
            end else if (int'(n_sat) >= int'(c_act)) begin
                load         = 1'b1;
                m_eos_next   = s_final_frame;
                m_short_next = 1'b0;
            end else if (s_final_frame) begin
                load         = 1'b1;
                m_eos_next   = 1'b1;
                m_short_next = 1'b1;
            end
        end
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // stream and flush counters
    always_comb begin
        frames_next  = frames_reg;
        flush_next   = flush_reg;
        flush_j_next = flush_j_reg;
        flush_n_next = flush_n_reg;
        if (accept) begin
            frames_next = s_final_frame ? '0 : n_sat;
        end
        if (flush_start) begin
            flush_next   = 1'b1;
            flush_j_next = LANE_W'(1);
            flush_n_next = n_sat;
        end else if (flush_beat) begin
            if (flush_j_reg == c_act - LANE_W'(1)) begin
                flush_next = 1'b0;
            end
            flush_j_next = flush_j_reg + LANE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg  <= '0;
            flush_reg   <= 1'b0;
            flush_j_reg <= '0;
            flush_n_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            frames_reg  <= frames_next;
            flush_reg   <= flush_next;
            flush_j_reg <= flush_j_next;
            flush_n_reg <= flush_n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_eos_reg   <= m_eos_next;
        m_short_reg <= m_short_next;
        if (load) begin
            m_code_reg <= lane_out;
        end
    end

    assign ctrl.push      = accept;
    assign ctrl.fl_load   = flush_start;
    assign ctrl.fl_step   = flush_beat;
    assign ctrl.flushing  = flush_reg;
    assign ctrl.reverse   = direction_reg;
    assign ctrl.zero_out  = m_short_next && !flush_reg;
    assign ctrl.lanes_act = c_act;
    assign ctrl.frames    = frames_reg;
    assign ctrl.flush_j   = flush_j_reg;
    assign ctrl.flush_n   = flush_n_reg;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        cdsk_lane #(
            .LANE      (k),
            .CODE_BITS (CODE_BITS)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .code_in    (code_in[k]),
            .begin_code (begin_code),
            .end_code   (end_code),
            .code_out   (lane_out[k])
        );
    end

    assign m_valid         = m_valid_reg;
    assign m_out_0         = m_code_reg[0];
    assign m_out_1         = m_code_reg[1];
    assign m_out_2         = m_code_reg[2];
    assign m_out_3         = m_code_reg[3];
    assign m_out_4         = m_code_reg[4];
    assign m_out_5         = m_code_reg[5];
    assign m_out_6         = m_code_reg[6];
    assign m_out_7         = m_code_reg[7];
    assign m_end_of_stream = m_eos_reg;
    assign m_too_short     = m_short_reg;

`ifndef SYNTHESIS
    a_flush_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> (flush_j_reg != '0 && flush_j_reg < c_act))
        else $error("flush beat index out of range");

    a_flush_follows_final: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_start |=> (flush_reg && flush_j_reg == LANE_W'(1)))
        else $error("final frame in apply mode did not start the flush");

    a_short_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_short_reg) |-> m_eos_reg)
        else $error("short-stream beat without end of stream");

    a_stream_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_final_frame) |=> (frames_reg == '0))
        else $error("frame count not cleared after final frame");
`endif

endmodule

/* rtl/core/cdsk_cell.sv */
// One history slot of a lane: stream history and flush line registers.
// Depends on cdsk_pkg.
module cdsk_cell #(
    parameter int CODE_BITS = cdsk_pkg::CODE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic                 fl_load,
    input  logic                 fl_step,
    input  logic [CODE_BITS-1:0] hist_in,
    input  logic [CODE_BITS-1:0] fl_in,
    output logic [CODE_BITS-1:0] hist_q,
    output logic [CODE_BITS-1:0] fl_q
);
    import cdsk_pkg::*;

    logic [CODE_BITS-1:0] hist_reg, hist_next;
    logic [CODE_BITS-1:0] fl_reg, fl_next;

    always_comb begin
        hist_next = push ? hist_in : hist_reg;
        if (fl_load) begin
            fl_next = hist_in;
        end else if (fl_step) begin
            fl_next = fl_in;
        end else begin
            fl_next = fl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        fl_reg <= fl_next;
    end

    assign hist_q = hist_reg;
    assign fl_q   = fl_reg;

endmodule

/* rtl/core/cdsk_lane.sv */
// One codebook lane: a chain of history cells and the output code selection.
// Depends on cdsk_pkg and cdsk_cell.
module cdsk_lane #(
    parameter int LANE      = 0,
    parameter int CODE_BITS = cdsk_pkg::CODE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cdsk_pkg::lane_ctrl_t ctrl,
    input  logic [CODE_BITS-1:0] code_in,
    input  logic [CODE_BITS-1:0] begin_code,
    input  logic [CODE_BITS-1:0] end_code,
    output logic [CODE_BITS-1:0] code_out
);
    import cdsk_pkg::*;

    localparam int TAP = (LANE > 0) ? LANE - 1 : 0;

    logic [CODE_BITS-1:0] hist    [HIST_DEPTH];
    logic [CODE_BITS-1:0] fl      [HIST_DEPTH];
    logic [CODE_BITS-1:0] hist_in [HIST_DEPTH];
    logic [CODE_BITS-1:0] fl_in   [HIST_DEPTH];
    logic                 active;
    logic                 push;
    logic [LANE_W-1:0]    lag;
    logic [HIDX_W-1:0]    rev_idx;

    assign active = int'(ctrl.lanes_act) > LANE;
    assign push   = ctrl.push & active;

    for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign hist_in[i] = code_in;
            assign fl_in[i]   = '0;
        end else begin : g_body
            assign hist_in[i] = hist[i-1];
            assign fl_in[i]   = fl[i-1];
        end

        cdsk_cell #(
            .CODE_BITS (CODE_BITS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .push    (push),
            .fl_load (ctrl.fl_load & push),
            .fl_step (ctrl.fl_step),
            .hist_in (hist_in[i]),
            .fl_in   (fl_in[i]),
            .hist_q  (hist[i]),
            .fl_q    (fl[i])
        );
    end

    // deskew lag: lane k waits C-1-k frames
    assign lag     = ctrl.lanes_act - LANE_W'(1) - LANE_W'(LANE);
    assign rev_idx = HIDX_W'(lag - LANE_W'(1));

    always_comb begin
        code_out = '0;
        if (!active || ctrl.zero_out) begin
            code_out = '0;
        end else if (ctrl.flushing) begin
            // flush beat j: lanes below j are spent, lanes not yet started show begin
            if (LANE < int'(ctrl.flush_j)) begin
                code_out = end_code;
            end else if (LANE >= int'(ctrl.flush_j) + int'(ctrl.flush_n)) begin
                code_out = begin_code;
            end else begin
                code_out = fl[TAP];
            end
        end else if (!ctrl.reverse) begin
            if (LANE == 0) begin
                code_out = code_in;
            end else if (int'(ctrl.frames) < LANE) begin
                code_out = begin_code;
            end else begin
                code_out = hist[TAP];
            end
        end else begin
            if (lag == '0) begin
                code_out = code_in;
            end else begin
                code_out = hist[rev_idx];
            end
        end
    end

endmodule

/* dv/tb_codebook_delay_skew.sv */
// Self-checking testbench for codebook_delay_skew: random frame streams through both channels,
// checked beat by beat against an in-bench skew/deskew predictor.
// Depends on cdsk_pkg and the codebook_delay_skew RTL.
module tb_codebook_delay_skew;
    timeunit 1ns;
    timeprecision 1ps;

    import cdsk_pkg::*;

    localparam int CB = 16;

    typedef struct packed {
        logic [LANES-1:0][CB-1:0] code;
        logic                     fin;
    } frame_t;

    typedef struct packed {
        logic [LANES-1:0][CB-1:0] lane;
        logic                     eos;
        logic                     too_short;
    } outf_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CB-1:0] m_out_0, m_out_1, m_out_2, m_out_3, m_out_4, m_out_5, m_out_6, m_out_7;
    logic m_end_of_stream, m_too_short;

    frame_t cur_frame = '0;
    logic   s_busy = 1'b0;
    outf_t  m_beat;

    frame_t frame_q[$];
    outf_t  out_q[$];

    // predictor copy of registers and state
    logic          cfg_dir = 1'b0;
    logic [3:0]    cfg_lanes = 4'd8;
    logic [CB-1:0] cfg_bt = 16'd1024;
    logic [CB-1:0] cfg_et = 16'd1025;
    logic [CB-1:0] hist [LANES][LANES];
    int            frames_seen = 0;

    int tx_idle = 32;
    int rx_idle = 77;
    int mismatches = 0;
    int n_beats = 0;
    int n_frames = 0;
    int n_streams = 0;
    int n_short = 0;
    int n_cfg = 0;
    int n_rand = 0;

    codebook_delay_skew DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_code_0(cur_frame.code[0]), .s_code_1(cur_frame.code[1]),
        .s_code_2(cur_frame.code[2]), .s_code_3(cur_frame.code[3]),
        .s_code_4(cur_frame.code[4]), .s_code_5(cur_frame.code[5]),
        .s_code_6(cur_frame.code[6]), .s_code_7(cur_frame.code[7]),
        .s_final_frame(cur_frame.fin),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_0(m_out_0), .m_out_1(m_out_1), .m_out_2(m_out_2), .m_out_3(m_out_3),
        .m_out_4(m_out_4), .m_out_5(m_out_5), .m_out_6(m_out_6), .m_out_7(m_out_7),
        .m_end_of_stream(m_end_of_stream), .m_too_short(m_too_short)
    );

    assign m_beat.lane = {m_out_7, m_out_6, m_out_5, m_out_4,
                          m_out_3, m_out_2, m_out_1, m_out_0};
    assign m_beat.eos = m_end_of_stream;
    assign m_beat.too_short = m_too_short;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int lanes_eff(input logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > LANES) return LANES;
        return int'(v);
    endfunction

    task automatic shift_hist(input logic [CB-1:0] x [LANES], input int c);
        for (int k = 0; k < c; k++) begin
            for (int i = LANES - 1; i > 0; i--) hist[k][i] = hist[k][i-1];
            hist[k][0] = x[k];
        end
    endtask

    // works out the output beats one accepted frame causes
    task automatic skew_frame(input frame_t f);
        logic [CB-1:0] x [LANES];
        outf_t res [LANES];
        int c, t, n, cnt;
        c = lanes_eff(cfg_lanes);
        cnt = 0;
        for (int k = 0; k < LANES; k++) x[k] = (k < c) ? f.code[k] : '0;
        if (cfg_dir == 1'b0) begin
            t = frames_seen;
            res[0] = '0;
            for (int k = 0; k < c; k++) begin
                if (k == 0) res[0].lane[0] = x[0];
                else if (t < k) res[0].lane[k] = cfg_bt;
                else res[0].lane[k] = hist[k][k-1];
            end
            cnt = 1;
            shift_hist(x, c);
            n = (frames_seen < 15) ? frames_seen + 1 : 15;
            frames_seen = n;
            if (f.fin) begin
                // flush: lanes below j are spent, lanes not yet started show begin
                for (int j = 1; j < c; j++) begin
                    res[cnt] = '0;
                    for (int k = 0; k < c; k++) begin
                        if (k < j) res[cnt].lane[k] = cfg_et;
                        else if (k - j >= n) res[cnt].lane[k] = cfg_bt;
                        else res[cnt].lane[k] = hist[k][k-j];
                    end
                    cnt++;
                end
                res[cnt-1].eos = 1'b1;
                frames_seen = 0;
            end
        end else begin
            n = (frames_seen < 15) ? frames_seen + 1 : 15;
            if (n >= c) begin
                res[0] = '0;
                for (int k = 0; k < c; k++)
                    res[0].lane[k] = (k == c - 1) ? x[k] : hist[k][c-2-k];
                res[0].eos = f.fin;
                cnt = 1;
            end else if (f.fin) begin
                res[0] = '0;
                res[0].eos = 1'b1;
                res[0].too_short = 1'b1;
                cnt = 1;
                n_short++;
            end
            shift_hist(x, c);
            frames_seen = f.fin ? 0 : n;
        end
        for (int i = 0; i < cnt; i++) out_q.push_back(res[i]);
    endtask

    // driver: payload and valid change on the falling edge
    always @(negedge aclk) begin
        if (aresetn && !s_busy) begin
            if (frame_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
                cur_frame = frame_q.pop_front();
                s_busy = 1'b1;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= rx_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            skew_frame(cur_frame);
            n_frames++;
            s_busy = 1'b0;
        end
    end

    task automatic check_field(input string what, input logic [CB-1:0] want, got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at beat %0d, %s: expected %h, got %h",
                         n_beats, what, want, got);
        end
    endtask

    // monitor
    always @(posedge aclk) begin : mon
        outf_t want;
        if (aresetn && m_valid && m_ready) begin
            if (out_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat %0d: %h", n_beats, m_beat);
            end else begin
                want = out_q.pop_front();
                for (int k = 0; k < LANES; k++)
                    check_field($sformatf("out_%0d", k), want.lane[k], m_beat.lane[k]);
                check_field("end_of_stream", CB'(want.eos), CB'(m_beat.eos));
                check_field("too_short", CB'(want.too_short), CB'(m_beat.too_short));
            end
            n_beats++;
        end
    end

    function automatic logic [CB-1:0] rand_code();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic logic [LANES-1:0][CB-1:0] rand_frame();
        logic [LANES-1:0][CB-1:0] v;
        for (int k = 0; k < LANES; k++) v[k] = rand_code();
        return v;
    endfunction

    task automatic push_frame(input logic [LANES-1:0][CB-1:0] codes, input logic fin);
        frame_t f;
        f.code = codes;
        f.fin = fin;
        frame_q.push_back(f);
        if (fin) n_streams++;
    endtask

    task automatic queue_stream(input int len);
        for (int i = 0; i < len; i++) push_frame(rand_frame(), i == len - 1);
        n_rand += len;
    endtask

    // hold the sender until every expected beat is out, then let any
    // result-less frame finish inside the block
    task automatic settle();
        while (frame_q.size() != 0 || s_busy || out_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_regs(input logic dir, input logic [3:0] lanes,
                            input logic [CB-1:0] bt, input logic [CB-1:0] et);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_DIRECTION;
        cfg_wdata <= CFG_DATA_W'(dir);
        @(negedge aclk);
        cfg_idx <= CFG_LANES;
        cfg_wdata <= CFG_DATA_W'(lanes);
        @(negedge aclk);
        cfg_idx <= CFG_BEGIN;
        cfg_wdata <= bt;
        @(negedge aclk);
        cfg_idx <= CFG_END;
        cfg_wdata <= et;
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_dir = dir;
        cfg_lanes = lanes;
        cfg_bt = bt;
        cfg_et = et;
        n_cfg++;
    endtask

    function automatic logic [CB-1:0] rand_token();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return CB'($urandom);
        endcase
    endfunction

    initial begin
        #2_000_000;
        $display("tb_codebook_delay_skew: done, errors");
        $finish;
    end

    initial begin : stim
        logic [3:0] lanes;
        int c, len, r;
        for (int k = 0; k < LANES; k++)
            for (int i = 0; i < LANES; i++) hist[k][i] = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset values, short apply streams with begin tokens left in the flush
        push_frame('0, 1'b0);
        push_frame('1, 1'b0);
        push_frame(rand_frame(), 1'b1);
        push_frame(rand_frame(), 1'b1);
        settle();
        // deskew: too-short stream, then one long enough to line up
        set_regs(1'b1, 4'd8, '0, '1);
        queue_stream(3);
        queue_stream(9);
        settle();
        set_regs(1'b0, 4'd1, '1, '0);
        queue_stream(2);
        settle();
        // lane count 0 behaves as one lane, 15 as all lanes
        set_regs(1'b1, 4'd0, rand_token(), rand_token());
        queue_stream(1);
        settle();
        set_regs(1'b0, 4'd15, rand_token(), rand_token());
        queue_stream(2);
        settle();
        set_regs(1'b1, 4'd15, rand_token(), rand_token());
        queue_stream(1);
        n_rand = 0;

        while (n_rand < 330) begin
            if (n_rand < 110) begin
                tx_idle = 32;
                rx_idle = 77;
            end else if (n_rand < 220) begin
                tx_idle = 77;
                rx_idle = 32;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            settle();
            r = $urandom_range(9);
            if (r == 0) lanes = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 9));
            else lanes = 4'($urandom_range(8, 1));
            set_regs(1'($urandom_range(1)), lanes, rand_token(), rand_token());
            c = lanes_eff(lanes);
            repeat ($urandom_range(4, 2)) begin
                r = $urandom_range(19);
                if (r < 3) len = 1;
                else if (r == 3) len = $urandom_range(20, 12);   // around and past the frame counter limit
                else len = $urandom_range(c + 3, 2);
                queue_stream(len);
            end
        end

        settle();
        $display("summary: %0d frames in %0d streams, %0d result beats, %0d short-stream flags",
                 n_frames, n_streams, n_beats, n_short);
        $display("summary: %0d register settings, %0d mismatches", n_cfg, mismatches);
        if (mismatches == 0) begin
            $display("tb_codebook_delay_skew: done, clean");
        end else begin
            $display("tb_codebook_delay_skew: done, errors");
        end
        $finish;
    end

endmodule
